/* hdl/buddy_block_allocator_assert.svh */
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buddy allocator assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buddy allocator assertion failed");

`endif

/* hdl/bba_pkg.sv */
// Package with the shared types and constants of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned NUM_W    = 11;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned ORD_W    = 5;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned APB_AW   = 2;
  localparam int unsigned APB_DW   = 32;

  localparam logic [APB_AW-1:0] REG_MAX_ORDER = 2'd0;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bba_cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } bba_status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_POP,
    S_SPLIT,
    S_MERGE,
    S_WALK,
    S_WALK_RD,
    S_PUSH
  } bba_state_e;

  typedef struct packed {
    logic             init;
    logic [ORD_W-1:0] max_order;
  } bba_cfg_t;

endpackage

/* hdl/bba_if.sv */
// Handshake interfaces for requests and results of the buddy block allocator.
`timescale 1ns / 1ps
interface bba_in_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [NUM_W-1:0] num_blocks;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, cmd, num_blocks, block_index, input ready);
  modport sink (input valid, cmd, num_blocks, block_index, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic [1:0]       status;

  modport source (output valid, result_index, status, input ready);
  modport sink (input valid, result_index, status, output ready);
endinterface

/* hdl/buddy_block_allocator.sv */
// Top level of the buddy block allocator: configuration port and sequencer.
`timescale 1ns / 1ps
// The allocator hands out and takes back power-of-two regions of a pool of
// 2^max_order blocks and returns one result per request. Each request is
// worked one at a time by a sequencer around a single link memory with
// registered read data: an allocation pops the head of the free list it takes
// from and then splits once per order it descends, and a free walks the free
// list of each order it visits in search of the buddy, merging while it finds
// one, and ends by pushing the region. After reset and after every write of
// max_order the block rebuilds its lists in S_INIT before it takes a request.
`include "buddy_block_allocator_assert.svh"
module buddy_block_allocator import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned MAX_ORDER  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  bba_in_if.sink            in_i,
  bba_out_if.source         out_o
);

  localparam int unsigned FLOOR_LOG = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int unsigned KCAP = (MAX_ORDER < FLOOR_LOG) ? MAX_ORDER : FLOOR_LOG;
  localparam logic [ORD_W-1:0] KCAP_O = ORD_W'(KCAP);
  localparam logic [ORD_W-1:0] RESET_O = (ORD_W'(10) < KCAP_O) ? ORD_W'(10) : KCAP_O;

  logic [ORD_W-1:0] max_order_q, max_order_d;
  logic [ORD_W-1:0] wr_val;
  logic cfg_we;
  bba_cfg_t cfg;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_MAX_ORDER);
  assign wr_val = ORD_W'(pwdata[CFG_W-1:0]);
  assign max_order_d = cfg_we ? ((wr_val > KCAP_O) ? KCAP_O : wr_val) : max_order_q;
  assign prdata = (paddr == REG_MAX_ORDER) ? APB_DW'(max_order_q) : '0;

  assign cfg.init      = cfg_we;
  assign cfg.max_order = max_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_order_q <= RESET_O;
    end else begin
      max_order_q <= max_order_d;
    end
  end

  bba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  `BBA_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_i.ready)
  `BBA_ASSERT_SAME(a_status_code, out_o.valid, (out_o.status == ST_OK) || (out_o.status == ST_OOM) || (out_o.status == ST_BAD))
  `BBA_ASSERT_SAME(a_fail_index_zero, out_o.valid && (out_o.status != ST_OK), out_o.result_index == '0)

endmodule

/* hdl/bba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/bba_ctrl.sv */
// Sequencer for allocate and free, with the free-list heads and the link memory.
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned MAX_ORDER  = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bba_cfg_t cfg_i,
  bba_in_if.sink   in_i,
  bba_out_if.source out_o
);

  localparam int unsigned IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned HW  = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int unsigned SW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned NH  = MAX_ORDER + 1;
  localparam int unsigned PW  = 18;
  localparam logic [IW-1:0] ONE_IW = IW'(1);
  localparam logic [SW-1:0] STEP_MAX = SW'(NUM_BLOCKS);

  bba_state_e state_q, state_d;
  logic [ORD_W-1:0] ord_q, ord_d, lvl_q, lvl_d;
  logic [IW-1:0] b_q, b_d, t_q, t_d, cur_q, cur_d, prev_q, prev_d;
  logic has_prev_q, has_prev_d, ok_q, ok_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [IW-1:0] head_q [NH];
  logic [IW-1:0] head_d [NH];
  logic [NH-1:0] hv_q, hv_d;
  logic out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  bba_status_e out_st_q, out_st_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [IW:0] wdata, rdata;

  logic [ORD_W-1:0] req_ord, found, lvl_n;
  logic found_ok, bad_size, bad_free;
  logic [PW-1:0] size_w, mask_w, end_w, pool_w;
  logic [IW-1:0] nb;

  bba_ram #(.WIDTH(IW + 1), .DEPTH(NUM_BLOCKS)) u_links (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    req_ord = '0;
    for (int k = 11; k >= 0; k--) begin
      if ((12'd1 << k) >= {1'b0, in_i.num_blocks}) begin
        req_ord = ORD_W'(k);
      end
    end
    found    = '0;
    found_ok = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (hv_q[k] && (ORD_W'(k) >= req_ord) && (ORD_W'(k) <= cfg_i.max_order)) begin
        found    = ORD_W'(k);
        found_ok = 1'b1;
      end
    end
    size_w   = PW'(1) << req_ord;
    mask_w   = size_w - PW'(1);
    end_w    = PW'(in_i.block_index) + size_w;
    pool_w   = PW'(1) << cfg_i.max_order;
    bad_size = (in_i.num_blocks == '0) || (req_ord > cfg_i.max_order);
    bad_free = ((PW'(in_i.block_index) & mask_w) != '0) || (end_w > pool_w);
    lvl_n    = lvl_q - ORD_W'(1);
    nb       = b_q + (ONE_IW << lvl_n);
  end

  assign in_i.ready        = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign out_o.valid       = out_valid_q;
  assign out_o.result_index = out_idx_q;
  assign out_o.status      = out_st_q;

  always_comb begin
    state_d    = state_q;
    ord_d      = ord_q;
    lvl_d      = lvl_q;
    b_d        = b_q;
    t_d        = t_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    ok_d       = ok_q;
    steps_d    = steps_q;
    head_d     = head_q;
    hv_d       = hv_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d  = out_idx_q;
    out_st_d   = out_st_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = cur_q;

    unique case (state_q)
      S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '0;
        for (int k = 0; k < NH; k++) begin
          head_d[k] = '0;
          hv_d[k]   = (ORD_W'(k) == cfg_i.max_order);
        end
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          ord_d = req_ord;
          if (bad_size || ((in_i.cmd == CMD_FREE) && bad_free)) begin
            out_valid_d = 1'b1;
            out_idx_d   = '0;
            out_st_d    = ST_BAD;
          end else if (in_i.cmd == CMD_ALLOC) begin
            if (!found_ok) begin
              out_valid_d = 1'b1;
              out_idx_d   = '0;
              out_st_d    = ST_OOM;
            end else begin
              lvl_d   = found;
              b_d     = head_q[found[HW-1:0]];
              raddr   = head_q[found[HW-1:0]];
              state_d = S_POP;
            end
          end else begin
            b_d     = IW'(in_i.block_index);
            state_d = S_MERGE;
          end
        end
      end
      S_POP: begin
        head_d[lvl_q[HW-1:0]] = rdata[IW-1:0];
        hv_d[lvl_q[HW-1:0]]   = rdata[IW];
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (lvl_q > ord_q) begin
          we    = 1'b1;
          waddr = nb;
          wdata = {hv_q[lvl_n[HW-1:0]], head_q[lvl_n[HW-1:0]]};
          head_d[lvl_n[HW-1:0]] = nb;
          hv_d[lvl_n[HW-1:0]]   = 1'b1;
          lvl_d = lvl_n;
        end else begin
          out_valid_d = 1'b1;
          out_idx_d   = IDX_W'(b_q);
          out_st_d    = ST_OK;
          state_d     = S_IDLE;
        end
      end
      S_MERGE: begin
        if (ord_q < cfg_i.max_order) begin
          t_d        = b_q ^ (ONE_IW << ord_q);
          cur_d      = head_q[ord_q[HW-1:0]];
          ok_d       = hv_q[ord_q[HW-1:0]];
          has_prev_d = 1'b0;
          steps_d    = '0;
          state_d    = S_WALK;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_WALK: begin
        if (ok_q && (steps_q < STEP_MAX)) begin
          raddr   = cur_q;
          state_d = S_WALK_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_WALK_RD: begin
        if (cur_q == t_q) begin
          if (has_prev_q) begin
            we    = 1'b1;
            waddr = prev_q;
            wdata = rdata;
          end else begin
            head_d[ord_q[HW-1:0]] = rdata[IW-1:0];
            hv_d[ord_q[HW-1:0]]   = rdata[IW];
          end
          b_d     = b_q & ~(ONE_IW << ord_q);
          ord_d   = ord_q + ORD_W'(1);
          state_d = S_MERGE;
        end else begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          ok_d       = rdata[IW];
          cur_d      = rdata[IW-1:0];
          steps_d    = steps_q + SW'(1);
          state_d    = S_WALK;
        end
      end
      S_PUSH: begin
        we    = 1'b1;
        waddr = b_q;
        wdata = {hv_q[ord_q[HW-1:0]], head_q[ord_q[HW-1:0]]};
        head_d[ord_q[HW-1:0]] = b_q;
        hv_d[ord_q[HW-1:0]]   = 1'b1;
        out_valid_d = 1'b1;
        out_idx_d   = '0;
        out_st_d    = ST_OK;
        state_d     = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase

    if (cfg_i.init) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      hv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q      <= ord_d;
    lvl_q      <= lvl_d;
    b_q        <= b_d;
    t_q        <= t_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    has_prev_q <= has_prev_d;
    ok_q       <= ok_d;
    steps_q    <= steps_d;
    head_q     <= head_d;
    out_idx_q  <= out_idx_d;
    out_st_q   <= out_st_d;
  end

endmodule
